// ----- sv/vgs_pkg.sv -----
package vgs_pkg;

    localparam int FRAME_COUNT_DEF   = 94;
    localparam int ROW_COUNT_DEF     = 16;
    localparam int STORE_COLUMNS_DEF = 282;
    localparam int DISPLAY_WIDTH_DEF = 281;

    localparam int SEG_BITS        = 96;
    localparam int BYTES_PER_FRAME = 24;
    localparam int SEG_BYTES       = 12;
    localparam int COL_BITS        = 9;
    localparam int ROW_BITS        = 4;
    localparam int FRAME_BITS      = 7;
    localparam int QUEUE_DEPTH     = 4;

    localparam logic [7:0] BRIGHT_RESET = 8'hFF;

    typedef enum logic [1:0] {
        OP_PIXEL  = 2'd0,
        OP_CLEAR  = 2'd1,
        OP_COMMIT = 2'd2,
        OP_FRAME  = 2'd3
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        logic                on;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PIX_RD,
        ST_PIX_WR,
        ST_COPY,
        ST_GATHER,
        ST_EMIT
    } t_state;

    function automatic logic [SEG_BITS-1:0] grid_bits(input logic [FRAME_BITS-1:0] f);
        logic [7:0]          g1;
        logic [7:0]          g2;
        logic [SEG_BITS-1:0] v;
        g1 = {1'b0, f} + 8'd1;
        g2 = {1'b0, f} + 8'd2;
        for (int n = 0; n < SEG_BITS; n++) begin
            v[n] = ((g1 <= 8'(SEG_BITS)) && ((8'(SEG_BITS) - g1) == 8'(n)))
                || ((g2 <= 8'(SEG_BITS)) && ((8'(SEG_BITS) - g2) == 8'(n)));
        end
        return v;
    endfunction

    function automatic logic [5:0] blank_delay(input logic [7:0] bright);
        logic [7:0]  t;
        logic [15:0] prod;
        t    = 8'hFF - bright;
        prod = 16'(t) * 16'd205;
        if (t == 8'd0) begin
            return 6'd1;
        end
        return 6'(prod >> 10);
    endfunction

    function automatic logic [7:0] reverse8(input logic [7:0] v);
        logic [7:0] r;
        for (int i = 0; i < 8; i++) begin
            r[i] = v[7-i];
        end
        return r;
    endfunction

endpackage

// ----- sv/vgs_front.sv -----
module vgs_front #(
    parameter int ROW_COUNT     = vgs_pkg::ROW_COUNT_DEF,
    parameter int STORE_COLUMNS = vgs_pkg::STORE_COLUMNS_DEF,
    parameter int DISPLAY_WIDTH = vgs_pkg::DISPLAY_WIDTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [1:0]    i_mode,
    input  logic [8:0]    i_pixel_x,
    input  logic [3:0]    i_pixel_y,
    input  logic          i_pixel_on,
    output logic          o_cmd_vld,
    output vgs_pkg::t_cmd o_cmd,
    input  logic          i_cmd_pop
);

    localparam int QA = $clog2(vgs_pkg::QUEUE_DEPTH);
    localparam int QC = $clog2(vgs_pkg::QUEUE_DEPTH + 1);

    vgs_pkg::t_cmd r_q [vgs_pkg::QUEUE_DEPTH];
    logic [QA-1:0] r_wp, n_wp;
    logic [QA-1:0] r_rp, n_rp;
    logic [QC-1:0] r_cnt, n_cnt;

    vgs_pkg::t_cmd cmd;
    logic          keep;
    logic          push;

    always_comb begin
        cmd.op  = vgs_pkg::t_op'(i_mode);
        cmd.col = vgs_pkg::COL_BITS'({1'b0, i_pixel_x} + 10'd1);
        cmd.row = i_pixel_y;
        cmd.on  = i_pixel_on;
        case (cmd.op)
            vgs_pkg::OP_PIXEL: begin
                keep = ({1'b0, i_pixel_x} < 10'(DISPLAY_WIDTH))
                    && (({1'b0, i_pixel_x} + 10'd1) < 10'(STORE_COLUMNS))
                    && ({1'b0, i_pixel_y} < 5'(ROW_COUNT));
            end
            default: begin
                keep = 1'b1;
            end
        endcase
    end

    assign o_ready   = (r_cnt != QC'(vgs_pkg::QUEUE_DEPTH));
    assign push      = i_valid && o_ready && keep;
    assign o_cmd_vld = (r_cnt != '0);
    assign o_cmd     = r_q[r_rp];

    always_comb begin
        n_wp  = push ? r_wp + 1'b1 : r_wp;
        n_rp  = i_cmd_pop ? r_rp + 1'b1 : r_rp;
        n_cnt = r_cnt + QC'(push) - QC'(i_cmd_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= cmd;
        end
    end

endmodule

// ----- sv/vgs_back.sv -----
module vgs_back #(
    parameter int FRAME_COUNT   = vgs_pkg::FRAME_COUNT_DEF,
    parameter int ROW_COUNT     = vgs_pkg::ROW_COUNT_DEF,
    parameter int STORE_COLUMNS = vgs_pkg::STORE_COLUMNS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_vld,
    input  vgs_pkg::t_cmd i_cmd,
    output logic          o_cmd_pop,
    input  logic [5:0]    i_blank_delay,
    input  logic          i_ready,
    output logic          o_valid,
    output logic [7:0]    o_frame_byte,
    output logic [4:0]    o_byte_index,
    output logic [6:0]    o_frame_number,
    output logic [5:0]    o_blank_delay,
    output logic          o_last_byte
);

    localparam int ROW_W = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int CNT_W = $clog2(ROW_COUNT + 1);
    localparam int COL_W = $clog2(STORE_COLUMNS);
    localparam int FB    = vgs_pkg::FRAME_BITS;
    localparam int SB    = vgs_pkg::SEG_BITS;

    logic [STORE_COLUMNS-1:0] r_draw_mem [ROW_COUNT];
    logic [STORE_COLUMNS-1:0] r_disp_mem [ROW_COUNT];
    logic [ROW_COUNT-1:0]     r_draw_vld;
    logic [ROW_COUNT-1:0]     r_disp_vld;
    logic [STORE_COLUMNS-1:0] r_draw_rd;
    logic                     r_draw_rd_vld;
    logic [STORE_COLUMNS-1:0] r_disp_rd;
    logic                     r_disp_rd_vld;

    vgs_pkg::t_state r_st, n_st;

    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic [vgs_pkg::COL_BITS-1:0] r_col, n_col;
    logic [vgs_pkg::ROW_BITS-1:0] r_row, n_row;
    logic                      r_on, n_on;
    logic [FB-1:0]             r_frame, n_frame;
    logic [9:0]                r_colbase, n_colbase;
    logic [SB-1:0]             r_seg, n_seg;
    logic [SB-1:0]             r_grid, n_grid;
    logic [4:0]                r_byte, n_byte;

    logic       r_out_vld, n_out_vld;
    logic [7:0] r_out_byte, n_out_byte;
    logic [4:0] r_out_idx, n_out_idx;
    logic [6:0] r_out_frame, n_out_frame;
    logic [5:0] r_out_delay, n_out_delay;
    logic       r_out_last, n_out_last;

    logic                     cnt_lt;
    logic                     cnt_end;
    logic [CNT_W-1:0]         cnt_m1;
    logic                     byte_end;
    logic                     load;
    logic [FB-1:0]            f_next;
    logic [STORE_COLUMNS-1:0] draw_row;
    logic [STORE_COLUMNS-1:0] disp_row;
    logic [STORE_COLUMNS-1:0] pix_row;

    logic [ROW_W-1:0]         draw_rd_addr;
    logic [ROW_W-1:0]         disp_rd_addr;
    logic [ROW_W-1:0]         disp_wr_addr;
    logic                     draw_we;
    logic                     disp_we;
    logic                     draw_clr;

    assign cnt_lt   = (r_cnt < CNT_W'(ROW_COUNT));
    assign cnt_end  = (r_cnt == CNT_W'(ROW_COUNT));
    assign cnt_m1   = r_cnt - 1'b1;
    assign byte_end = (r_byte == 5'(vgs_pkg::BYTES_PER_FRAME - 1));
    assign f_next   = (r_frame == FB'(FRAME_COUNT - 1)) ? '0 : r_frame + 1'b1;
    assign draw_row = r_draw_rd_vld ? r_draw_rd : '0;
    assign disp_row = r_disp_rd_vld ? r_disp_rd : '0;

    always_comb begin
        pix_row = draw_row;
        pix_row[r_col[COL_W-1:0]] = r_on;
    end

    always_comb begin
        n_st = r_st;
        case (r_st)
            vgs_pkg::ST_IDLE: begin
                if (i_cmd_vld) begin
                    case (i_cmd.op)
                        vgs_pkg::OP_PIXEL:  n_st = vgs_pkg::ST_PIX_RD;
                        vgs_pkg::OP_COMMIT: n_st = vgs_pkg::ST_COPY;
                        vgs_pkg::OP_FRAME:  n_st = vgs_pkg::ST_GATHER;
                        default:            n_st = vgs_pkg::ST_IDLE;
                    endcase
                end
            end
            vgs_pkg::ST_PIX_RD: n_st = vgs_pkg::ST_PIX_WR;
            vgs_pkg::ST_PIX_WR: n_st = vgs_pkg::ST_IDLE;
            vgs_pkg::ST_COPY: begin
                if (cnt_end) begin
                    n_st = vgs_pkg::ST_IDLE;
                end
            end
            vgs_pkg::ST_GATHER: begin
                if (cnt_end) begin
                    n_st = vgs_pkg::ST_EMIT;
                end
            end
            vgs_pkg::ST_EMIT: begin
                if (load && byte_end) begin
                    n_st = vgs_pkg::ST_IDLE;
                end
            end
            default: n_st = vgs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_pop    = 1'b0;
        draw_clr     = 1'b0;
        draw_we      = 1'b0;
        disp_we      = 1'b0;
        load         = 1'b0;
        draw_rd_addr = '0;
        disp_rd_addr = '0;
        disp_wr_addr = cnt_m1[ROW_W-1:0];
        case (r_st)
            vgs_pkg::ST_IDLE: begin
                o_cmd_pop = i_cmd_vld;
                draw_clr  = i_cmd_vld && (i_cmd.op == vgs_pkg::OP_CLEAR);
            end
            vgs_pkg::ST_PIX_RD: begin
                draw_rd_addr = r_row[ROW_W-1:0];
            end
            vgs_pkg::ST_PIX_WR: begin
                draw_we = 1'b1;
            end
            vgs_pkg::ST_COPY: begin
                draw_rd_addr = cnt_lt ? r_cnt[ROW_W-1:0] : '0;
                disp_we      = (r_cnt != '0);
            end
            vgs_pkg::ST_GATHER: begin
                disp_rd_addr = cnt_lt ? r_cnt[ROW_W-1:0] : '0;
            end
            vgs_pkg::ST_EMIT: begin
                load = !r_out_vld || i_ready;
            end
            default: begin
                o_cmd_pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        logic [9:0] c;
        logic [2:0] b;
        logic [5:0] six;
        logic [6:0] base;
        n_cnt       = r_cnt;
        n_col       = r_col;
        n_row       = r_row;
        n_on        = r_on;
        n_frame     = r_frame;
        n_colbase   = r_colbase;
        n_seg       = r_seg;
        n_grid      = r_grid;
        n_byte      = r_byte;
        n_out_byte  = r_out_byte;
        n_out_idx   = r_out_idx;
        n_out_frame = r_out_frame;
        n_out_delay = r_out_delay;
        n_out_last  = r_out_last;
        n_out_vld   = i_ready ? 1'b0 : r_out_vld;
        for (int k = 0; k < 3; k++) begin
            c    = r_colbase + 10'(k);
            b[k] = (c < 10'(STORE_COLUMNS)) ? disp_row[c[COL_W-1:0]] : 1'b0;
        end
        six  = r_frame[0] ? {b[0], 1'b0, b[1], 1'b0, b[2], 1'b0}
                          : {1'b0, b[2], 1'b0, b[1], 1'b0, b[0]};
        base = 7'(cnt_m1) * 7'd6;
        case (r_st)
            vgs_pkg::ST_IDLE: begin
                n_cnt = '0;
                if (i_cmd_vld) begin
                    n_col = i_cmd.col;
                    n_row = i_cmd.row;
                    n_on  = i_cmd.on;
                    if (i_cmd.op == vgs_pkg::OP_FRAME) begin
                        n_frame   = f_next;
                        n_colbase = 10'(f_next) * 10'd3;
                        n_seg     = '0;
                        n_grid    = vgs_pkg::grid_bits(f_next);
                        n_byte    = '0;
                    end
                end
            end
            vgs_pkg::ST_COPY: begin
                n_cnt = r_cnt + 1'b1;
            end
            vgs_pkg::ST_GATHER: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt != '0) begin
                    n_seg[base +: 6] = six;
                end
            end
            vgs_pkg::ST_EMIT: begin
                if (load) begin
                    n_out_vld   = 1'b1;
                    n_out_idx   = r_byte;
                    n_out_frame = r_frame;
                    n_out_last  = byte_end;
                    n_out_delay = byte_end ? i_blank_delay : 6'd0;
                    n_byte      = r_byte + 1'b1;
                    if (r_byte < 5'(vgs_pkg::SEG_BYTES)) begin
                        n_out_byte = vgs_pkg::reverse8(r_seg[7:0]);
                        n_seg      = r_seg >> 8;
                    end else begin
                        n_out_byte = r_grid[SB-1 -: 8];
                        n_grid     = r_grid << 8;
                    end
                end
            end
            default: begin
                n_cnt = r_cnt;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= vgs_pkg::ST_IDLE;
            r_frame    <= '0;
            r_out_vld  <= 1'b0;
            r_draw_vld <= '0;
            r_disp_vld <= '0;
        end else begin
            r_st      <= n_st;
            r_frame   <= n_frame;
            r_out_vld <= n_out_vld;
            if (draw_clr) begin
                r_draw_vld <= '0;
            end else if (draw_we) begin
                r_draw_vld[r_row[ROW_W-1:0]] <= 1'b1;
            end
            if (disp_we) begin
                r_disp_vld[disp_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt       <= n_cnt;
        r_col       <= n_col;
        r_row       <= n_row;
        r_on        <= n_on;
        r_colbase   <= n_colbase;
        r_seg       <= n_seg;
        r_grid      <= n_grid;
        r_byte      <= n_byte;
        r_out_byte  <= n_out_byte;
        r_out_idx   <= n_out_idx;
        r_out_frame <= n_out_frame;
        r_out_delay <= n_out_delay;
        r_out_last  <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (draw_we) begin
            r_draw_mem[r_row[ROW_W-1:0]] <= pix_row;
        end
        r_draw_rd     <= r_draw_mem[draw_rd_addr];
        r_draw_rd_vld <= r_draw_vld[draw_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (disp_we) begin
            r_disp_mem[disp_wr_addr] <= draw_row;
        end
        r_disp_rd     <= r_disp_mem[disp_rd_addr];
        r_disp_rd_vld <= r_disp_vld[disp_rd_addr];
    end

    assign o_valid        = r_out_vld;
    assign o_frame_byte   = r_out_byte;
    assign o_byte_index   = r_out_idx;
    assign o_frame_number = r_out_frame;
    assign o_blank_delay  = r_out_delay;
    assign o_last_byte    = r_out_last;

endmodule

// ----- sv/vfd_grid_scan_frame_builder_top.sv -----
// Frame builder for a grid-pair scanned vacuum fluorescent display. Each request carries a
// mode: a pixel write, a draw store clear, a commit of the draw store to the display store
// (one row per cycle, read from the draw store and written to the display store), or a frame
// request, which advances the frame counter and yields 24 shift-register bytes: the display
// store is read one row per cycle to gather the segment bits, then one byte leaves per cycle
// while the consumer keeps up. A four-deep command queue lets requests be taken while a frame
// is still being sent, and pixel writes outside the display are dropped on entry. Both stores
// read as zero after reset without a clearing pass. The brightness register at address 0 sets
// the blanking delay carried on the last byte of each frame.
module vfd_grid_scan_frame_builder_top #(
    parameter int FRAME_COUNT   = vgs_pkg::FRAME_COUNT_DEF,
    parameter int ROW_COUNT     = vgs_pkg::ROW_COUNT_DEF,
    parameter int STORE_COLUMNS = vgs_pkg::STORE_COLUMNS_DEF,
    parameter int DISPLAY_WIDTH = vgs_pkg::DISPLAY_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_mode,
    input  logic [8:0]  i_pixel_x,
    input  logic [3:0]  i_pixel_y,
    input  logic        i_pixel_on,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_frame_byte,
    output logic [4:0]  o_byte_index,
    output logic [6:0]  o_frame_number,
    output logic [5:0]  o_blank_delay,
    output logic        o_last_byte
);

    logic [7:0]    r_bright;
    logic          cmd_vld;
    logic          cmd_pop;
    vgs_pkg::t_cmd cmd;
    logic [5:0]    delay;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {24'd0, r_bright} : 32'd0;
    assign delay  = vgs_pkg::blank_delay(r_bright);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bright <= vgs_pkg::BRIGHT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == 1'b0)) begin
            r_bright <= pwdata[7:0];
        end
    end

    vgs_front #(
        .ROW_COUNT     (ROW_COUNT),
        .STORE_COLUMNS (STORE_COLUMNS),
        .DISPLAY_WIDTH (DISPLAY_WIDTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_mode     (i_mode),
        .i_pixel_x  (i_pixel_x),
        .i_pixel_y  (i_pixel_y),
        .i_pixel_on (i_pixel_on),
        .o_cmd_vld  (cmd_vld),
        .o_cmd      (cmd),
        .i_cmd_pop  (cmd_pop)
    );

    vgs_back #(
        .FRAME_COUNT   (FRAME_COUNT),
        .ROW_COUNT     (ROW_COUNT),
        .STORE_COLUMNS (STORE_COLUMNS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_vld      (cmd_vld),
        .i_cmd          (cmd),
        .o_cmd_pop      (cmd_pop),
        .i_blank_delay  (delay),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_frame_byte   (o_frame_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_number (o_frame_number),
        .o_blank_delay  (o_blank_delay),
        .o_last_byte    (o_last_byte)
    );

endmodule

// ----- dv/tb_vfd_grid_scan_frame_builder_top.sv -----
`timescale 1ns / 100ps

module tb_vfd_grid_scan_frame_builder_top;

    localparam logic [2:0]  BRIGHTNESS_ADDR = 3'd0;
    localparam int          SLOTS_PER_FRAME = 3;
    localparam int          ROW_PITCH       = 6;
    localparam int          SETTLE_CYCLES   = 200;
    localparam int          PHASE_ITEMS     = 34;
    localparam int          MIN_FRAMES      = 100;
    localparam int          IDLE_PERCENT    = 31;
    localparam int unsigned RUN_LIMIT_NS    = 5_000_000;

    typedef struct {
        logic [7:0] data;
        logic [4:0] index;
        logic [6:0] frame;
        logic [5:0] delay;
        logic       last;
    } t_frame_byte;

    class t_frame_scoreboard;
        bit          draw_px [vgs_pkg::ROW_COUNT_DEF][vgs_pkg::STORE_COLUMNS_DEF];
        bit          shown_px[vgs_pkg::ROW_COUNT_DEF][vgs_pkg::STORE_COLUMNS_DEF];
        int          frame_ctr;
        logic [7:0]  brightness;
        t_frame_byte expected_bytes[$];
        int          mismatches;

        function new();
            frame_ctr  = 0;
            brightness = vgs_pkg::BRIGHT_RESET;
            mismatches = 0;
        endfunction

        function void load_brightness(logic [7:0] level);
            brightness = level;
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction

        function void note_failure(string msg);
            mismatches++;
            if (mismatches <= 10) begin
                $display("%s", msg);
            end
        endfunction

        function void note_request(vgs_pkg::t_op op, logic [8:0] x, logic [3:0] y, logic on);
            logic [7:0]  frame_bytes[vgs_pkg::BYTES_PER_FRAME];
            int          col;
            int          pos;
            int          slot;
            int          n;
            int          offtime;
            t_frame_byte item;
            case (op)
                vgs_pkg::OP_PIXEL: begin
                    col = int'(x) + 1;
                    if (int'(x) < vgs_pkg::DISPLAY_WIDTH_DEF && int'(y) < vgs_pkg::ROW_COUNT_DEF
                        && col < vgs_pkg::STORE_COLUMNS_DEF) begin
                        draw_px[y][col] = on;
                    end
                end
                vgs_pkg::OP_CLEAR: begin
                    foreach (draw_px[r, c]) begin
                        draw_px[r][c] = 1'b0;
                    end
                end
                vgs_pkg::OP_COMMIT: begin
                    shown_px = draw_px;
                end
                vgs_pkg::OP_FRAME: begin
                    frame_ctr = (frame_ctr + 1) % vgs_pkg::FRAME_COUNT_DEF;
                    foreach (frame_bytes[i]) begin
                        frame_bytes[i] = 8'h00;
                    end
                    for (int r = 0; r < vgs_pkg::ROW_COUNT_DEF; r++) begin
                        for (int k = 0; k < SLOTS_PER_FRAME; k++) begin
                            col  = SLOTS_PER_FRAME * frame_ctr + k;
                            slot = (frame_ctr % 2 == 0) ? 2 * k : 5 - 2 * k;
                            pos  = slot + ROW_PITCH * r;
                            if (col < vgs_pkg::STORE_COLUMNS_DEF && shown_px[r][col]
                                && pos < vgs_pkg::SEG_BITS) begin
                                frame_bytes[pos / 8] |= 8'h80 >> (pos % 8);
                            end
                        end
                    end
                    for (int g = frame_ctr + 1; g <= frame_ctr + 2; g++) begin
                        if (g >= 1 && g <= vgs_pkg::SEG_BITS) begin
                            n = vgs_pkg::SEG_BITS - g;
                            frame_bytes[vgs_pkg::SEG_BYTES + vgs_pkg::SEG_BYTES - 1 - n / 8]
                                |= 8'h01 << (n % 8);
                        end
                    end
                    offtime = 255 - int'(brightness);
                    offtime = (offtime == 0) ? 1 : offtime / 5;
                    for (int i = 0; i < vgs_pkg::BYTES_PER_FRAME; i++) begin
                        item.data  = frame_bytes[i];
                        item.index = 5'(i);
                        item.frame = 7'(frame_ctr);
                        item.last  = (i == vgs_pkg::BYTES_PER_FRAME - 1);
                        item.delay = item.last ? 6'(offtime) : 6'd0;
                        expected_bytes.push_back(item);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void check_byte(t_frame_byte got);
            t_frame_byte want;
            if (expected_bytes.size() == 0) begin
                note_failure($sformatf("unexpected byte: data %02h index %0d frame %0d",
                    got.data, got.index, got.frame));
                return;
            end
            want = expected_bytes.pop_front();
            if (got.data !== want.data || got.index !== want.index || got.frame !== want.frame
                || got.delay !== want.delay || got.last !== want.last) begin
                note_failure($sformatf({"byte mismatch: expected data %02h index %0d frame %0d ",
                    "delay %0d last %0d, got data %02h index %0d frame %0d delay %0d last %0d"},
                    want.data, want.index, want.frame, want.delay, want.last,
                    got.data, got.index, got.frame, got.delay, got.last));
            end
        endfunction
    endclass

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        psel       = 1'b0;
    logic        penable    = 1'b0;
    logic        pwrite     = 1'b0;
    logic [2:0]  paddr      = '0;
    logic [31:0] pwdata     = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid    = 1'b0;
    logic        o_ready;
    logic [1:0]  i_mode     = '0;
    logic [8:0]  i_pixel_x  = '0;
    logic [3:0]  i_pixel_y  = '0;
    logic        i_pixel_on = 1'b0;
    logic        o_valid;
    logic        i_ready    = 1'b0;
    logic [7:0]  o_frame_byte;
    logic [4:0]  o_byte_index;
    logic [6:0]  o_frame_number;
    logic [5:0]  o_blank_delay;
    logic        o_last_byte;

    t_frame_scoreboard sb;
    bit                steady = 1'b0;
    int                items_sent = 0;
    int                frames_sent = 0;
    logic [7:0]        bright_levels[7];

    vfd_grid_scan_frame_builder_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_mode         (i_mode),
        .i_pixel_x      (i_pixel_x),
        .i_pixel_y      (i_pixel_y),
        .i_pixel_on     (i_pixel_on),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_frame_byte   (o_frame_byte),
        .o_byte_index   (o_byte_index),
        .o_frame_number (o_frame_number),
        .o_blank_delay  (o_blank_delay),
        .o_last_byte    (o_last_byte)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        i_ready = steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    always @(posedge i_clk) begin
        t_frame_byte got;
        if (i_rst_n && o_valid && i_ready) begin
            got.data  = o_frame_byte;
            got.index = o_byte_index;
            got.frame = o_frame_number;
            got.delay = o_blank_delay;
            got.last  = o_last_byte;
            sb.check_byte(got);
        end
    end

    task automatic send_request(input vgs_pkg::t_op op, input logic [8:0] x,
                                input logic [3:0] y, input logic on);
        @(negedge i_clk);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid    = 1'b1;
        i_mode     = op;
        i_pixel_x  = x;
        i_pixel_y  = y;
        i_pixel_on = on;
        do @(posedge i_clk); while (!o_ready);
        sb.note_request(op, x, y, on);
        if (!(op == vgs_pkg::OP_PIXEL && int'(x) >= vgs_pkg::DISPLAY_WIDTH_DEF)) begin
            items_sent++;
        end
        if (op == vgs_pkg::OP_FRAME) begin
            frames_sent++;
        end
    endtask

    task automatic send_random_fields(input vgs_pkg::t_op op);
        send_request(op, 9'($urandom_range(0, 511)), 4'($urandom_range(0, 15)),
                     1'($urandom_range(0, 1)));
    endtask

    function automatic logic [8:0] pick_column();
        int pick;
        int col;
        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            col = SLOTS_PER_FRAME
                * ((sb.frame_ctr + $urandom_range(1, 3)) % vgs_pkg::FRAME_COUNT_DEF)
                + $urandom_range(0, SLOTS_PER_FRAME - 1);
            return (col == 0) ? 9'd0 : 9'(col - 1);
        end
        if (pick < 85) begin
            return 9'($urandom_range(0, vgs_pkg::DISPLAY_WIDTH_DEF - 1));
        end
        return 9'($urandom_range(0, 511));
    endfunction

    task automatic random_burst();
        if ($urandom_range(0, 99) < 12) begin
            repeat ($urandom_range(1, 4)) begin
                send_random_fields(vgs_pkg::t_op'($urandom_range(0, 3)));
            end
        end else begin
            if ($urandom_range(0, 9) == 0) begin
                send_random_fields(vgs_pkg::OP_CLEAR);
            end
            repeat ($urandom_range(0, 5)) begin
                send_request(vgs_pkg::OP_PIXEL, pick_column(), 4'($urandom_range(0, 15)),
                             $urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 9) < 7) begin
                send_random_fields(vgs_pkg::OP_COMMIT);
            end
            repeat ($urandom_range(1, 4)) send_random_fields(vgs_pkg::OP_FRAME);
        end
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_brightness(input logic [7:0] level);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = BRIGHTNESS_ADDR;
        pwdata  = {24'd0, level};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.load_brightness(level);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== {24'd0, level}) begin
            sb.note_failure($sformatf("brightness readback: expected %08h, got %08h",
                {24'd0, level}, prdata));
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int phase_start;
        sb = new();
        bright_levels = '{8'd0, 8'd254, 8'd128, 8'd1, 8'($urandom_range(2, 253)), 8'd250, 8'd255};
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Pixels at both ends of the display, dropped columns, a darkened pixel, then commits, a clear and frames.
        send_request(vgs_pkg::OP_PIXEL,  9'd0,   4'd0,  1'b1);
        send_request(vgs_pkg::OP_PIXEL,  9'd280, 4'd15, 1'b1);
        send_request(vgs_pkg::OP_PIXEL,  9'd281, 4'd7,  1'b1);
        send_request(vgs_pkg::OP_PIXEL,  9'd511, 4'd15, 1'b1);
        send_request(vgs_pkg::OP_PIXEL,  9'd2,   4'd15, 1'b1);
        send_request(vgs_pkg::OP_PIXEL,  9'd3,   4'd9,  1'b1);
        send_request(vgs_pkg::OP_PIXEL,  9'd4,   4'd0,  1'b1);
        send_request(vgs_pkg::OP_PIXEL,  9'd3,   4'd9,  1'b0);
        send_request(vgs_pkg::OP_PIXEL,  9'd3,   4'd10, 1'b1);
        send_request(vgs_pkg::OP_COMMIT, 9'd0,   4'd0,  1'b0);
        send_request(vgs_pkg::OP_FRAME,  9'd0,   4'd0,  1'b0);
        send_request(vgs_pkg::OP_PIXEL,  9'd5,   4'd0,  1'b1);
        send_request(vgs_pkg::OP_PIXEL,  9'd6,   4'd15, 1'b1);
        send_request(vgs_pkg::OP_PIXEL,  9'd7,   4'd4,  1'b1);
        send_request(vgs_pkg::OP_COMMIT, 9'd0,   4'd0,  1'b0);
        send_request(vgs_pkg::OP_FRAME,  9'h1FF, 4'hF,  1'b1);
        send_request(vgs_pkg::OP_CLEAR,  9'd0,   4'd0,  1'b0);
        send_request(vgs_pkg::OP_FRAME,  9'd0,   4'd0,  1'b0);
        send_request(vgs_pkg::OP_PIXEL,  9'd8,   4'd2,  1'b1);
        send_request(vgs_pkg::OP_COMMIT, 9'd0,   4'd0,  1'b0);
        send_request(vgs_pkg::OP_FRAME,  9'd0,   4'd0,  1'b0);
        send_request(vgs_pkg::OP_FRAME,  9'd0,   4'd0,  1'b0);

        for (int p = 0; p < 7; p++) begin
            drain();
            write_brightness(bright_levels[p]);
            steady      = (p == 3);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS
                   || (p == 6 && frames_sent < MIN_FRAMES)) begin
                random_burst();
            end
        end
        steady = 1'b0;
        drain();

        if (sb.mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
